### rtl/tcg_pkg.sv
package tcg_pkg;

   // field and datapath widths
   localparam int COUNT_BITS  = 16;
   localparam int COLOUR_BITS = 24;
   localparam int LEVEL_BITS  = 8;
   localparam int POS_BITS    = 17;
   localparam int FRAC_BITS   = 17;
   localparam int OFFSET_BITS = 15;
   localparam int RECIP_BITS  = 18;
   localparam int CSR_INDEX_BITS = 2;

   // segment boundaries and widths on the Q0.16 cycle
   localparam logic [POS_BITS-1:0]    SEG1_START = 17'd21627;
   localparam logic [POS_BITS-1:0]    SEG2_START = 17'd43254;
   localparam logic [OFFSET_BITS-1:0] SEG0_WIDTH = 15'd21627;
   localparam logic [OFFSET_BITS-1:0] SEG1_WIDTH = 15'd21627;
   localparam logic [OFFSET_BITS-1:0] SEG2_WIDTH = 15'd22282;

   // floor(2^32 / width): offset * recip >> 16 lands on the fraction or one below
   localparam logic [RECIP_BITS-1:0] SEG01_RECIP =
      RECIP_BITS'(64'h1_0000_0000 / 64'(SEG0_WIDTH));
   localparam logic [RECIP_BITS-1:0] SEG2_RECIP =
      RECIP_BITS'(64'h1_0000_0000 / 64'(SEG2_WIDTH));

   typedef enum logic [1:0] {
      SEG_FIRST  = 2'd0,
      SEG_SECOND = 2'd1,
      SEG_THIRD  = 2'd2
   } seg_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLOUR_FIRST  = 2'd0,
      CSR_COLOUR_SECOND = 2'd1,
      CSR_COLOUR_THIRD  = 2'd2,
      CSR_STEP_COUNT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COLOUR_BITS-1:0] colour_first;
      logic [COLOUR_BITS-1:0] colour_second;
      logic [COLOUR_BITS-1:0] colour_third;
   } colours_type;

   // clamped step index entering the divider
   typedef struct packed {
      logic                  valid;
      logic                  single;
      logic [COUNT_BITS-1:0] index;
   } idx_item_type;

   // position on the cycle, Q0.16, 0..65536
   typedef struct packed {
      logic                valid;
      logic                single;
      logic [POS_BITS-1:0] pos;
   } pos_item_type;

   // segment and fraction within it, Q0.16, 0..65536
   typedef struct packed {
      logic                 valid;
      seg_type              seg;
      logic [FRAC_BITS-1:0] frac;
   } frac_item_type;

   typedef struct packed {
      logic                  valid;
      seg_type               seg;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
   } pix_item_type;

endpackage

### rtl/tcg_div.sv
module tcg_div
   import tcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [COUNT_BITS-1:0] divisor,
   input  idx_item_type          in_item,
   output pos_item_type          out_item
);

   // restoring divide of index*65536 by divisor, two quotient bits per stage
   localparam int STEPS_PER_STAGE = 2;
   localparam int STAGES = (POS_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   logic [STAGES-1:0]     valid_ff;
   logic [STAGES-1:0]     single_ff;
   logic [COUNT_BITS-1:0] rem_ff [STAGES];
   logic [POS_BITS-1:0]   quo_ff [STAGES];

   genvar g;
   generate
      for (g = 0; g < STAGES; g++) begin : g_stage
         localparam int HI_BIT = POS_BITS - 1 - g * STEPS_PER_STAGE;
         localparam int NSTEP  = (HI_BIT + 1 < STEPS_PER_STAGE) ? HI_BIT + 1 : STEPS_PER_STAGE;

         logic                  v_src;
         logic                  s_src;
         logic [COUNT_BITS-1:0] rem_src;
         logic [POS_BITS-1:0]   quo_src;
         logic [COUNT_BITS-1:0] rem_in;
         logic [POS_BITS-1:0]   quo_in;
         logic [COUNT_BITS:0]   cand;

         if (g == 0) begin : g_head
            assign v_src   = in_item.valid;
            assign s_src   = in_item.single;
            assign rem_src = in_item.index;
            assign quo_src = '0;
         end else begin : g_body
            assign v_src   = valid_ff[g-1];
            assign s_src   = single_ff[g-1];
            assign rem_src = rem_ff[g-1];
            assign quo_src = quo_ff[g-1];
         end

         // the top quotient bit takes the index itself: index <= divisor
         always_comb begin
            rem_in = rem_src;
            quo_in = quo_src;
            cand   = '0;
            for (int j = 0; j < NSTEP; j++) begin
               if (g == 0 && j == 0) begin
                  cand = {1'b0, rem_in};
               end else begin
                  cand = {rem_in, 1'b0};
               end
               if (cand >= {1'b0, divisor}) begin
                  quo_in[HI_BIT-j] = 1'b1;
                  rem_in = COUNT_BITS'(cand - {1'b0, divisor});
               end else begin
                  rem_in = cand[COUNT_BITS-1:0];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[g] <= 1'b0;
            end else if (en) begin
               valid_ff[g] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               single_ff[g] <= s_src;
               rem_ff[g]    <= rem_in;
               quo_ff[g]    <= quo_in;
            end
         end
      end
   endgenerate

   always_comb begin
      out_item.valid  = valid_ff[STAGES-1];
      out_item.single = single_ff[STAGES-1];
      out_item.pos    = quo_ff[STAGES-1];
   end

endmodule

### rtl/tcg_frac.sv
module tcg_frac
   import tcg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  pos_item_type  in_item,
   output frac_item_type out_item
);

   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   seg_type                s1_seg_ff, s2_seg_ff, s3_seg_ff, s4_seg_ff;
   logic [OFFSET_BITS-1:0] s1_off_ff, s2_off_ff, s3_off_ff;
   logic [FRAC_BITS-1:0]   s2_est_ff, s3_est_ff, s4_frac_ff;
   logic [31:0]            s3_bound_ff;

   seg_type                s1_seg_in;
   logic [OFFSET_BITS-1:0] s1_off_in;
   logic [RECIP_BITS-1:0]  recip;
   logic [32:0]            recip_prod;
   logic [FRAC_BITS-1:0]   s2_est_in;
   logic [OFFSET_BITS-1:0] width;
   logic [FRAC_BITS-1:0]   est_next;
   logic [31:0]            s3_bound_in;
   logic [FRAC_BITS-1:0]   s3_next;
   logic [FRAC_BITS-1:0]   s4_frac_in;

   // stage 1: pick the segment and the offset into it
   always_comb begin
      if (in_item.single) begin
         s1_seg_in = SEG_FIRST;
         s1_off_in = '0;
      end else if (in_item.pos < SEG1_START) begin
         s1_seg_in = SEG_FIRST;
         s1_off_in = in_item.pos[OFFSET_BITS-1:0];
      end else if (in_item.pos < SEG2_START) begin
         s1_seg_in = SEG_SECOND;
         s1_off_in = OFFSET_BITS'(in_item.pos - SEG1_START);
      end else begin
         s1_seg_in = SEG_THIRD;
         s1_off_in = OFFSET_BITS'(in_item.pos - SEG2_START);
      end
   end

   // stage 2: estimate offset*65536/width by the reciprocal
   always_comb begin
      case (s1_seg_ff)
         SEG_THIRD: recip = SEG2_RECIP;
         default:   recip = SEG01_RECIP;
      endcase
      recip_prod = 33'(s1_off_ff) * 33'(recip);
      s2_est_in  = recip_prod[32:16];
   end

   // stage 3: (estimate + 1) * width, to test whether the estimate is one short
   always_comb begin
      case (s2_seg_ff)
         SEG_FIRST:  width = SEG0_WIDTH;
         SEG_SECOND: width = SEG1_WIDTH;
         default:    width = SEG2_WIDTH;
      endcase
      est_next    = s2_est_ff + 1'b1;
      s3_bound_in = 32'(est_next) * 32'(width);
   end

   // stage 4: correct the estimate
   always_comb begin
      s3_next = s3_est_ff + 1'b1;
      if ({1'b0, s3_off_ff, 16'h0000} >= s3_bound_ff) begin
         s4_frac_in = s3_next;
      end else begin
         s4_frac_in = s3_est_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_item.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_seg_ff   <= s1_seg_in;
         s1_off_ff   <= s1_off_in;
         s2_seg_ff   <= s1_seg_ff;
         s2_off_ff   <= s1_off_ff;
         s2_est_ff   <= s2_est_in;
         s3_seg_ff   <= s2_seg_ff;
         s3_off_ff   <= s2_off_ff;
         s3_est_ff   <= s2_est_ff;
         s3_bound_ff <= s3_bound_in;
         s4_seg_ff   <= s3_seg_ff;
         s4_frac_ff  <= s4_frac_in;
      end
   end

   always_comb begin
      out_item.valid = s4_valid_ff;
      out_item.seg   = s4_seg_ff;
      out_item.frac  = s4_frac_ff;
   end

endmodule

### rtl/tcg_mix.sv
module tcg_mix
   import tcg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  colours_type   colours,
   input  frac_item_type in_item,
   output pix_item_type  out_item
);

   localparam int CHANNELS = 3;

   logic                         m1_valid_ff, m2_valid_ff;
   seg_type                      m1_seg_ff, m2_seg_ff;
   logic [FRAC_BITS-1:0]         m1_frac_ff;
   logic [LEVEL_BITS-1:0]        m1_base_ff [CHANNELS];
   logic signed [LEVEL_BITS:0]   m1_diff_ff [CHANNELS];
   logic [LEVEL_BITS-1:0]        m2_base_ff [CHANNELS];
   logic signed [26:0]           m2_prod_ff [CHANNELS];

   logic [COLOUR_BITS-1:0]       stop_a;
   logic [COLOUR_BITS-1:0]       stop_b;
   logic [LEVEL_BITS-1:0]        base_in [CHANNELS];
   logic signed [LEVEL_BITS:0]   diff_in [CHANNELS];
   logic signed [FRAC_BITS:0]    frac_s;
   logic signed [26:0]           prod_in [CHANNELS];
   logic signed [10:0]           shift_q [CHANNELS];
   logic signed [10:0]           level_s [CHANNELS];
   logic [LEVEL_BITS-1:0]        level [CHANNELS];

   // stage 1: stops for the segment, per channel difference
   always_comb begin
      case (in_item.seg)
         SEG_FIRST: begin
            stop_a = colours.colour_first;
            stop_b = colours.colour_second;
         end
         SEG_SECOND: begin
            stop_a = colours.colour_second;
            stop_b = colours.colour_third;
         end
         SEG_THIRD: begin
            stop_a = colours.colour_third;
            stop_b = colours.colour_first;
         end
         default: begin
            stop_a = colours.colour_first;
            stop_b = colours.colour_first;
         end
      endcase
      // channel 0 red (top byte), 1 green, 2 blue
      for (int c = 0; c < CHANNELS; c++) begin
         base_in[c] = stop_a[COLOUR_BITS-1-LEVEL_BITS*c -: LEVEL_BITS];
         diff_in[c] = signed'({1'b0, stop_b[COLOUR_BITS-1-LEVEL_BITS*c -: LEVEL_BITS]})
                    - signed'({1'b0, base_in[c]});
      end
   end

   // stage 2: difference times fraction
   always_comb begin
      frac_s = signed'({1'b0, m1_frac_ff});
      for (int c = 0; c < CHANNELS; c++) begin
         prod_in[c] = 27'(m1_diff_ff[c]) * 27'(frac_s);
      end
   end

   // output: base plus floored step, clamped to a byte
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         shift_q[c] = signed'(m2_prod_ff[c][26:16]);
         level_s[c] = signed'({3'b000, m2_base_ff[c]}) + shift_q[c];
         if (level_s[c] < 0) begin
            level[c] = '0;
         end else if (level_s[c] > 11'sd255) begin
            level[c] = '1;
         end else begin
            level[c] = level_s[c][LEVEL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= in_item.valid;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_seg_ff  <= in_item.seg;
         m1_frac_ff <= in_item.frac;
         m2_seg_ff  <= m1_seg_ff;
         for (int c = 0; c < CHANNELS; c++) begin
            m1_base_ff[c] <= base_in[c];
            m1_diff_ff[c] <= diff_in[c];
            m2_base_ff[c] <= m1_base_ff[c];
            m2_prod_ff[c] <= prod_in[c];
         end
      end
   end

   always_comb begin
      out_item.valid = m2_valid_ff;
      out_item.seg   = m2_seg_ff;
      out_item.red   = level[0];
      out_item.green = level[1];
      out_item.blue  = level[2];
   end

endmodule

### rtl/tcg_out.sv
module tcg_out
   import tcg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pix_item_type up_item,
   output logic         up_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata
);

   logic         rsp_valid_ff;
   logic [31:0]  rsp_data_ff;
   logic         skid_full_ff;
   logic [31:0]  skid_data_ff;

   logic         up_take;
   logic         rsp_free;
   logic [31:0]  up_data;

   // fields from the low bit up: red, green, blue, segment, zero fill
   assign up_data  = {6'b000000, up_item.seg, up_item.blue, up_item.green, up_item.red};
   assign up_ready = ~skid_full_ff;
   assign up_take  = up_item.valid & ~skid_full_ff;
   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_full_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= up_take;
         end
      end else if (up_take) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_full_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (up_take) begin
            rsp_data_ff <= up_data;
         end
      end else if (up_take) begin
         skid_data_ff <= up_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/three_colour_gradient.sv
// Channel  Dir  Handshake              Payload (low bit up)
// req      in   req_tvalid/req_tready  req_tdata[15:0] step_index
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: red, green, blue, segment, zero fill
// csr      in   csr_we                 csr_index selects register, csr_wdata value
//
// One step index accepted per cycle while the pipeline is not held; its colour reaches rsp
// through 17 register stages: the input stage, the 17-bit position divide, two
// quotient bits per stage over nine stages, then fraction, mix and output stages.
// Reset is synchronous and clears all valid bits; registers return to their
// reset values (colours black, 256 steps).
// A stall on rsp fills one skid entry, then the whole pipeline holds in place.
module three_colour_gradient
   import tcg_pkg::*;
#(
   parameter int INDEX_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // step_index
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // red, green, blue, segment, 6 zero bits
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COLOUR_BITS-1:0]    csr_wdata
);

   localparam int USED_BITS = (INDEX_BITS < COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

   logic [COLOUR_BITS-1:0] colour_first_ff;
   logic [COLOUR_BITS-1:0] colour_second_ff;
   logic [COLOUR_BITS-1:0] colour_third_ff;
   logic [COUNT_BITS-1:0]  divisor_ff;
   logic                   single_ff;

   idx_item_type           in_item_ff;
   idx_item_type           in_item_in;
   logic [COUNT_BITS-1:0]  index_raw;
   logic                   en;
   colours_type            colours;
   pos_item_type           pos_item;
   frac_item_type          frac_item;
   pix_item_type           pix_item;

   // configuration: step count kept as divisor (count - 1) and a one-step flag
   always_ff @(posedge clock) begin
      if (reset) begin
         colour_first_ff  <= '0;
         colour_second_ff <= '0;
         colour_third_ff  <= '0;
         divisor_ff       <= 16'd255;
         single_ff        <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COLOUR_FIRST:  colour_first_ff  <= csr_wdata;
            CSR_COLOUR_SECOND: colour_second_ff <= csr_wdata;
            CSR_COLOUR_THIRD:  colour_third_ff  <= csr_wdata;
            CSR_STEP_COUNT: begin
               divisor_ff <= csr_wdata[COUNT_BITS-1:0] - 1'b1;
               single_ff  <= (csr_wdata[COUNT_BITS-1:0] <= 16'd1);
            end
            default: ;
         endcase
      end
   end

   assign colours.colour_first  = colour_first_ff;
   assign colours.colour_second = colour_second_ff;
   assign colours.colour_third  = colour_third_ff;

   // whole pipeline moves unless the skid entry is occupied
   assign req_tready = en & ~reset;

   // input stage: mask and clamp the index to the last step, or zero it for a single step
   always_comb begin
      index_raw         = COUNT_BITS'(req_tdata[USED_BITS-1:0]);
      in_item_in.valid  = req_tvalid & req_tready;
      in_item_in.single = single_ff;
      if (single_ff) begin
         in_item_in.index = '0;
      end else if (index_raw > divisor_ff) begin
         in_item_in.index = divisor_ff;
      end else begin
         in_item_in.index = index_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_item_ff.valid <= 1'b0;
      end else if (en) begin
         in_item_ff.valid <= in_item_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_item_ff.single <= in_item_in.single;
         in_item_ff.index  <= in_item_in.index;
      end
   end

   tcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .divisor  (divisor_ff),
      .in_item  (in_item_ff),
      .out_item (pos_item)
   );

   tcg_frac u_frac (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_item  (pos_item),
      .out_item (frac_item)
   );

   tcg_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .colours  (colours),
      .in_item  (frac_item),
      .out_item (pix_item)
   );

   tcg_out u_out (
      .clock      (clock),
      .reset      (reset),
      .up_item    (pix_item),
      .up_ready   (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/tcg_checker.sv
module tcg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // input side only backs off after the output was stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready low without an output stall");

   // zero fill above the segment field
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:26] == 6'b000000)
      else $error("rsp_tdata fill bits not zero");

endmodule

bind three_colour_gradient tcg_checker u_tcg_checker (.*);
